// ===== rtl/pva_pkg.sv =====
// Shared types and constants for the polyphonic voice allocator.
package pva_pkg;

    // Defaults for the top-level parameters
    localparam int VOICES_DEF    = 8;
    localparam int TIME_BITS_DEF = 32;

    // Fixed field widths
    localparam int NOTE_W    = 7;
    localparam int VEL_W     = 7;
    localparam int CMD_W     = 2;
    localparam int VIDX_W    = 3;
    localparam int SLOT_W    = 3;
    localparam int TIME_IN_W = 32;
    localparam int S_DATA_W  = 56;
    localparam int M_DATA_W  = 16;

    // Input command codes
    localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ENV_DONE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_REL_ALL  = 2'd3;

    // Result action codes
    localparam logic ACT_START   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_START,
        ST_RELEASE,
        ST_FLUSH
    } pva_state_t;

    // Control of the steal compare unit
    typedef struct packed {
        logic init;
        logic step;
        logic newest;
    } steal_ctrl_t;

endpackage

// ===== rtl/pva_steal_unit.sv =====
// Steal candidate tracker: one voice per cycle against the released and fallback bounds.
module pva_steal_unit #(
    parameter int VOICES = pva_pkg::VOICES_DEF,
    parameter int TW     = pva_pkg::TIME_IN_W
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pva_pkg::steal_ctrl_t      ctrl,
    input  logic [TW-1:0]             now,
    input  logic [$clog2(VOICES)-1:0] vidx,
    input  logic [TW-1:0]             vtime,
    input  logic                      vgate,
    output logic [$clog2(VOICES)-1:0] pick
);

    localparam int IW = $clog2(VOICES);

    logic [TW-1:0] rel_b_reg;
    logic [TW-1:0] any_b_reg;
    logic [IW-1:0] rel_idx_reg;
    logic [IW-1:0] any_idx_reg;
    logic          rel_v_reg;
    logic          any_v_reg;
    logic          rel_ok;
    logic          any_ok;

    // Compare the visited voice's start time against both bounds
    always_comb
    begin
        if (ctrl.newest)
        begin
            rel_ok = vtime > rel_b_reg;
            any_ok = vtime > any_b_reg;
        end
        else
        begin
            rel_ok = vtime < rel_b_reg;
            any_ok = vtime < any_b_reg;
        end
    end

    // Track candidate flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rel_v_reg <= 1'b0;
            any_v_reg <= 1'b0;
        end
        else if (ctrl.init)
        begin
            rel_v_reg <= 1'b0;
            any_v_reg <= 1'b0;
        end
        else if (ctrl.step)
        begin
            if (!vgate && rel_ok)
            begin
                rel_v_reg <= 1'b1;
            end
            else if (any_ok)
            begin
                any_v_reg <= 1'b1;
            end
        end
    end

    // Track bounds and candidate indexes
    always_ff @(posedge clk)
    begin
        if (ctrl.init)
        begin
            rel_b_reg <= ctrl.newest ? '0 : now;
            any_b_reg <= ctrl.newest ? '0 : now;
        end
        else if (ctrl.step)
        begin
            if (!vgate && rel_ok)
            begin
                rel_b_reg   <= vtime;
                rel_idx_reg <= vidx;
            end
            else if (any_ok)
            begin
                any_b_reg   <= vtime;
                any_idx_reg <= vidx;
            end
        end
    end

    // Released candidate first, then fallback, else voice 0
    always_comb
    begin
        if (rel_v_reg)
        begin
            pick = rel_idx_reg;
        end
        else if (any_v_reg)
        begin
            pick = any_idx_reg;
        end
        else
        begin
            pick = '0;
        end
    end

endmodule

// ===== rtl/poly_voice_allocator_unit.sv =====
// Polyphonic voice allocator top level: voice state, scan sequencer and result register.
//
// Input transactions arrive on s_axis: tuser carries the command, tdata the note,
// velocity, voice index and time. Results leave on m_axis: tuser is the action,
// tdata the slot and note, tlast marks the final result of one input.
// steal_mode is written through cfg_wr_en / cfg_wr_data; the user must write it only
// while the block is idle, as the block itself does not enforce this. A note-on scans
// all VOICES voices, one per cycle, through a compare unit that also tracks steal
// candidates; the start result is loaded into the output register from ST_START once
// that register is free, and the next input can be taken in the cycle after the load.
// Note-off and release-all scan the voices the same way and emit each release as it is
// found (one result is held back to learn tlast); the input is done after the release
// scan and the flush state when the receiver keeps up. Envelope-finished and note-on with
// note zero complete in the accept cycle with no result. A new input is taken only once
// the last is done. When the receiver stalls, the scan holds on its next result and
// s_axis_tready stays low; a finished result waits in the output register while a new
// input is accepted. Reset clears all voices, steal_mode and the output register.
module poly_voice_allocator_unit #(
    parameter int VOICES    = pva_pkg::VOICES_DEF,
    parameter int TIME_BITS = pva_pkg::TIME_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_wr_data,    // steal_mode
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // note[6:0], velocity[13:7], voice_index[16:14], event_ms[48:17], zeros above
    input  logic [pva_pkg::S_DATA_W-1:0]   s_axis_tdata,
    input  logic [pva_pkg::CMD_W-1:0]      s_axis_tuser,   // command[1:0]
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [pva_pkg::M_DATA_W-1:0]   m_axis_tdata,   // slot[2:0], note_out[9:3], zeros
    output logic                           m_axis_tuser,   // action[0]
    output logic                           m_axis_tlast
);

    localparam int IW = $clog2(VOICES);
    localparam int TW = (TIME_BITS < pva_pkg::TIME_IN_W) ? TIME_BITS : pva_pkg::TIME_IN_W;
    localparam int NW = pva_pkg::NOTE_W;

    // Input field unpacking
    logic [NW-1:0]                 s_note;
    logic [pva_pkg::VEL_W-1:0]     s_vel;
    logic [pva_pkg::VIDX_W-1:0]    s_vidx;
    logic [TW-1:0]                 s_time;
    logic                          s_acc;

    assign s_note = s_axis_tdata[6:0];
    assign s_vel  = s_axis_tdata[13:7];
    assign s_vidx = s_axis_tdata[16:14];
    assign s_time = TW'(s_axis_tdata[48:17]);
    assign s_acc  = s_axis_tvalid && s_axis_tready;

    // Voice state
    logic [NW-1:0]     note_mem [VOICES];
    logic [TW-1:0]     time_mem [VOICES];
    logic [VOICES-1:0] active_reg;
    logic [VOICES-1:0] gate_reg;

    // Sequencer and item registers
    pva_pkg::pva_state_t state_reg, state_next;
    logic          mode_reg;
    logic [IW-1:0] idx_reg;
    logic [NW-1:0] note_q_reg;
    logic [TW-1:0] time_q_reg;
    logic          rel_all_reg;
    logic          found_reg;
    logic [IW-1:0] sel_reg;
    logic          pend_v_reg;
    logic [IW-1:0] pend_slot_reg;
    logic [NW-1:0] pend_note_reg;

    // Output register
    logic                             out_v_reg;
    logic [pva_pkg::SLOT_W-1:0]       out_slot_reg;
    logic [NW-1:0]                    out_note_reg;
    logic                             out_act_reg;
    logic                             out_last_reg;

    // Datapath signals
    logic                  idx_last;
    logic [NW-1:0]         cur_note;
    logic                  free_hit;
    logic                  rel_hit;
    logic                  out_free;
    logic                  stall;
    logic [IW-1:0]         steal_pick;
    logic [IW-1:0]         slot_sel;
    logic                  is_start;
    logic                  is_release;
    pva_pkg::steal_ctrl_t  steal_ctrl;
    logic                  adv;
    logic                  do_start;
    logic                  do_rel;
    logic                  load_out;
    logic                  ld_act;
    logic [IW-1:0]         ld_slot;
    logic [NW-1:0]         ld_note;
    logic                  ld_last;

    assign idx_last  = (idx_reg == IW'(VOICES - 1));
    assign cur_note  = note_mem[idx_reg];
    assign free_hit  = !active_reg[idx_reg] || (cur_note == note_q_reg);
    assign rel_hit   = rel_all_reg || (cur_note == note_q_reg);
    assign out_free  = !out_v_reg || m_axis_tready;
    assign stall     = rel_hit && pend_v_reg && !out_free;
    assign slot_sel  = found_reg ? sel_reg : steal_pick;

    // Decode the arriving command
    assign is_start   = (s_axis_tuser == pva_pkg::CMD_NOTE_ON) && (s_vel != '0)
                        && (s_note != '0);
    assign is_release = ((s_axis_tuser == pva_pkg::CMD_NOTE_ON) && (s_vel == '0))
                        || (s_axis_tuser == pva_pkg::CMD_NOTE_OFF)
                        || (s_axis_tuser == pva_pkg::CMD_REL_ALL);

    pva_steal_unit #(
        .VOICES (VOICES),
        .TW     (TW)
    ) u_steal (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (steal_ctrl),
        .now   (s_time),
        .vidx  (idx_reg),
        .vtime (time_mem[idx_reg]),
        .vgate (gate_reg[idx_reg]),
        .pick  (steal_pick)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pva_pkg::ST_IDLE:
            begin
                if (s_acc && is_start)
                begin
                    state_next = pva_pkg::ST_ALLOC;
                end
                else if (s_acc && is_release)
                begin
                    state_next = pva_pkg::ST_RELEASE;
                end
            end
            pva_pkg::ST_ALLOC:
            begin
                if (idx_last)
                begin
                    state_next = pva_pkg::ST_START;
                end
            end
            pva_pkg::ST_START:
            begin
                if (out_free)
                begin
                    state_next = pva_pkg::ST_IDLE;
                end
            end
            pva_pkg::ST_RELEASE:
            begin
                if (!stall && idx_last)
                begin
                    state_next = pva_pkg::ST_FLUSH;
                end
            end
            pva_pkg::ST_FLUSH:
            begin
                if (!pend_v_reg || out_free)
                begin
                    state_next = pva_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pva_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        s_axis_tready     = 1'b0;
        steal_ctrl.init   = 1'b0;
        steal_ctrl.step   = 1'b0;
        steal_ctrl.newest = mode_reg;
        adv      = 1'b0;
        do_start = 1'b0;
        do_rel   = 1'b0;
        load_out = 1'b0;
        ld_act   = pva_pkg::ACT_RELEASE;
        ld_slot  = pend_slot_reg;
        ld_note  = pend_note_reg;
        ld_last  = 1'b0;
        unique case (state_reg)
            pva_pkg::ST_IDLE:
            begin
                s_axis_tready   = 1'b1;
                steal_ctrl.init = s_acc;
            end
            pva_pkg::ST_ALLOC:
            begin
                adv             = 1'b1;
                steal_ctrl.step = 1'b1;
            end
            pva_pkg::ST_START:
            begin
                if (out_free)
                begin
                    do_start = 1'b1;
                    load_out = 1'b1;
                    ld_act   = pva_pkg::ACT_START;
                    ld_slot  = slot_sel;
                    ld_note  = note_q_reg;
                    ld_last  = 1'b1;
                end
            end
            pva_pkg::ST_RELEASE:
            begin
                if (!stall)
                begin
                    adv      = 1'b1;
                    do_rel   = rel_hit;
                    load_out = rel_hit && pend_v_reg;
                end
            end
            pva_pkg::ST_FLUSH:
            begin
                if (pend_v_reg && out_free)
                begin
                    load_out = 1'b1;
                    ld_last  = 1'b1;
                end
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= pva_pkg::ST_IDLE;
            mode_reg   <= 1'b0;
            found_reg  <= 1'b0;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            // Restart the scan on each accepted item
            if (s_acc)
            begin
                idx_reg    <= '0;
                found_reg  <= 1'b0;
                pend_v_reg <= 1'b0;
            end
            else
            begin
                if (adv)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (state_reg == pva_pkg::ST_ALLOC && !found_reg && free_hit)
                begin
                    found_reg <= 1'b1;
                end
                if (do_rel)
                begin
                    pend_v_reg <= 1'b1;
                end
                else if (state_reg == pva_pkg::ST_FLUSH && load_out)
                begin
                    pend_v_reg <= 1'b0;
                end
            end
            // Hold a result until taken
            if (load_out)
            begin
                out_v_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            note_q_reg  <= s_note;
            time_q_reg  <= s_time;
            rel_all_reg <= (s_axis_tuser == pva_pkg::CMD_REL_ALL);
        end
        if (state_reg == pva_pkg::ST_ALLOC && !found_reg && free_hit)
        begin
            sel_reg <= idx_reg;
        end
        if (do_rel)
        begin
            pend_slot_reg <= idx_reg;
            pend_note_reg <= cur_note;
        end
        if (load_out)
        begin
            out_act_reg  <= ld_act;
            out_slot_reg <= pva_pkg::SLOT_W'(ld_slot);
            out_note_reg <= ld_note;
            out_last_reg <= ld_last;
        end
    end

    // Voice flags: release, envelope done, start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            gate_reg   <= '0;
        end
        else
        begin
            if (s_acc && s_axis_tuser == pva_pkg::CMD_ENV_DONE
                && 32'(s_vidx) < VOICES)
            begin
                active_reg[IW'(s_vidx)] <= 1'b0;
                gate_reg[IW'(s_vidx)]   <= 1'b0;
            end
            if (do_rel)
            begin
                gate_reg[idx_reg] <= 1'b0;
            end
            if (do_start)
            begin
                active_reg[slot_sel] <= 1'b1;
                gate_reg[slot_sel]   <= 1'b1;
            end
        end
    end

    // Voice note and start time store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VOICES; i++)
            begin
                note_mem[i] <= '0;
                time_mem[i] <= '0;
            end
        end
        else if (do_start)
        begin
            note_mem[slot_sel] <= note_q_reg;
            time_mem[slot_sel] <= time_q_reg;
        end
    end

    // Result port
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tuser  = out_act_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {(pva_pkg::M_DATA_W - pva_pkg::SLOT_W - NW)'(0),
                            out_note_reg, out_slot_reg};

    // A start is always the only result of its input
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == pva_pkg::ACT_START) |-> m_axis_tlast)
        else $error("start result without tlast");

    // No held-back release survives into idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pva_pkg::ST_IDLE) |-> !pend_v_reg)
        else $error("pending release left in idle");

    // A stalled release scan keeps its voice index
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pva_pkg::ST_RELEASE && stall) |=> $stable(idx_reg))
        else $error("scan index moved during stall");

    // Scan index stays within the voice set
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pva_pkg::ST_ALLOC || state_reg == pva_pkg::ST_RELEASE)
        |-> (32'(idx_reg) < VOICES))
        else $error("scan index out of range");

endmodule
